>>> hw/rtl/f32sc_pkg.sv
// Shared constants and the result type for the single-precision scale core.
// No dependencies.
`timescale 1ns / 1ps
package f32sc_pkg;
    localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
    localparam logic [31:0] ABS_MASK   = 32'h7fff_ffff;
    localparam logic [31:0] INF_BITS   = 32'h7f80_0000;
    localparam logic [31:0] QUIET_BIT  = 32'h0040_0000;
    localparam logic [31:0] FRAC_MASK  = 32'h007f_ffff;
    localparam int          EXP_MAX    = 254;
    localparam int          SHIFT_MAX  = 25;

    typedef struct packed {
        logic [31:0] result_bits;
        logic        flag_invalid;
        logic        flag_overflow;
        logic        flag_underflow;
        logic        flag_inexact;
    } result_t;
endpackage

>>> hw/rtl/float32_scale_by_power_of_two_core.sv
// Top level of the single-precision scale-by-power-of-two core.
// Depends on f32sc_pkg.
`timescale 1ns / 1ps
// Computes x * 2^scale on raw single-precision bits with invalid, overflow,
// underflow and inexact flags. One request is accepted per cycle while the
// result register is empty or m_tready is high; its result appears in the
// next cycle from the result register, held while m_tready is low. Results
// come from one pass through normalise, exponent add and subnormal rounding.
module float32_scale_by_power_of_two_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // [31:0] x_bits, [63:32] scale
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // [31:0] result_bits, [32] flag_invalid,
                                  // [33] flag_overflow, [34] flag_underflow,
                                  // [35] flag_inexact, [39:36] zero
);
    logic [31:0]        x;
    logic signed [31:0] scale;
    logic [31:0]        mag;
    logic [22:0]        frac;
    logic [4:0]         lz;
    logic [23:0]        m_norm;
    logic signed [33:0] e_norm;
    logic signed [33:0] ex;
    logic [4:0]         sh;
    logic [23:0]        q;
    logic [23:0]        rem;
    logic [24:0]        half;
    logic [24:0]        q_rnd;
    f32sc_pkg::result_t res;
    f32sc_pkg::result_t res_reg;
    logic               valid_reg;

    assign x     = s_tdata[31:0];
    assign scale = s_tdata[63:32];
    assign mag   = x & f32sc_pkg::ABS_MASK;
    assign frac  = mag[22:0];

    // leading zeros of the fraction, for subnormal operands
    always_comb begin
        lz = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (frac[i]) lz = 5'(22 - i);
        end
    end

    always_comb begin
        if (mag[30:23] == 8'd0) begin
            m_norm = {1'b0, frac} << (lz + 5'd1);
            e_norm = -34'(lz);
        end else begin
            m_norm = {1'b1, frac};
            e_norm = 34'(mag[30:23]);
        end
        ex    = e_norm + 34'(scale);
        sh    = 5'(34'sd1 - ex);
        q     = m_norm >> sh;
        rem   = m_norm & ((24'd1 << sh) - 24'd1);
        // half needs a 25th bit when the whole significand is shifted out
        half  = 25'd1 << (sh - 5'd1);
        q_rnd = {1'b0, q};
        if ({1'b0, rem} > half || ({1'b0, rem} == half && q[0])) q_rnd = {1'b0, q} + 25'd1;
    end

    always_comb begin
        res = '0;
        res.result_bits = x;
        if (mag > f32sc_pkg::INF_BITS) begin
            if ((mag & f32sc_pkg::QUIET_BIT) == 32'd0) begin
                res.result_bits  = x | f32sc_pkg::QUIET_BIT;
                res.flag_invalid = 1'b1;
            end
        end else if (mag == f32sc_pkg::INF_BITS || mag == 32'd0 || scale == 32'sd0) begin
            res.result_bits = x;
        end else if (ex > 34'(f32sc_pkg::EXP_MAX)) begin
            res.result_bits   = (x & f32sc_pkg::SIGN_MASK) | f32sc_pkg::INF_BITS;
            res.flag_overflow = 1'b1;
            res.flag_inexact  = 1'b1;
        end else if (ex >= 34'sd1) begin
            res.result_bits = {x[31], ex[7:0], m_norm[22:0]};
        end else if (34'sd1 - ex > 34'(f32sc_pkg::SHIFT_MAX)) begin
            res.result_bits    = x & f32sc_pkg::SIGN_MASK;
            res.flag_underflow = 1'b1;
            res.flag_inexact   = 1'b1;
        end else begin
            res.result_bits    = (x & f32sc_pkg::SIGN_MASK) | {7'd0, q_rnd};
            res.flag_underflow = rem != 24'd0;
            res.flag_inexact   = rem != 24'd0;
        end
    end

    assign s_tready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, res_reg.flag_inexact, res_reg.flag_underflow,
                       res_reg.flag_overflow, res_reg.flag_invalid, res_reg.result_bits};

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ovf_inx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33] |-> m_tdata[35])
        else $error("overflow without inexact");
    a_unf_inx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> m_tdata[35])
        else $error("underflow without inexact");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0({m_tdata[32], m_tdata[33], m_tdata[34]}))
        else $error("conflicting flags");
endmodule

>>> bench/tb_top.sv
// Self-checking bench for float32_scale_by_power_of_two_core: drives operand/scale
// requests, predicts each scaled result and its flags, and compares them in order.
// Depends on f32sc_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 200;

    typedef struct packed {
        logic [31:0] scale;
        logic [31:0] x_bits;
    } request_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        s_tready_q = 1'b0;

    request_t            pending_requests[$];
    f32sc_pkg::result_t  expected_results[$];
    bit       stimulus_done = 1'b0;
    int       fail_count = 0;
    int       results_seen = 0;
    int       idle_cycles = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       cycle_count = 0;

    float32_scale_by_power_of_two_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 aclk = ~aclk;

    // Scale x by 2^scale on raw bits, with exception flags.
    function automatic f32sc_pkg::result_t scale_float(logic [31:0] x,
                                                       logic signed [31:0] scale);
        f32sc_pkg::result_t r;
        logic [31:0] sign;
        logic [31:0] mag;
        logic [31:0] man;
        logic [31:0] q;
        logic [31:0] rem;
        logic [31:0] half;
        longint expo;
        longint ex;
        int sh;
        r = '0;
        r.result_bits = x;
        sign = x & f32sc_pkg::SIGN_MASK;
        mag = x & f32sc_pkg::ABS_MASK;
        if (mag > f32sc_pkg::INF_BITS) begin
            if ((mag & f32sc_pkg::QUIET_BIT) == 0) begin
                r.result_bits = x | f32sc_pkg::QUIET_BIT;
                r.flag_invalid = 1'b1;
            end
        end else if (mag == f32sc_pkg::INF_BITS || mag == 0 || scale == 0) begin
            r.result_bits = x;
        end else begin
            expo = mag >> 23;
            man = mag & f32sc_pkg::FRAC_MASK;
            if (expo == 0) begin
                // normalise the subnormal operand
                expo = 1;
                while (man[23] == 1'b0) begin
                    man = man << 1;
                    expo--;
                end
            end else begin
                man[23] = 1'b1;
            end
            ex = expo + longint'(scale);
            if (ex > f32sc_pkg::EXP_MAX) begin
                r.result_bits = sign | f32sc_pkg::INF_BITS;
                r.flag_overflow = 1'b1;
                r.flag_inexact = 1'b1;
            end else if (ex >= 1) begin
                r.result_bits = sign | (32'(ex) << 23) | (man & f32sc_pkg::FRAC_MASK);
            end else if (1 - ex > f32sc_pkg::SHIFT_MAX) begin
                r.result_bits = sign;
                r.flag_underflow = 1'b1;
                r.flag_inexact = 1'b1;
            end else begin
                sh = int'(1 - ex);
                q = man >> sh;
                rem = man & ((32'd1 << sh) - 1);
                half = 32'd1 << (sh - 1);
                if (rem > half || (rem == half && q[0]))
                    q++;
                if (rem != 0) begin
                    r.flag_inexact = 1'b1;
                    r.flag_underflow = 1'b1;
                end
                r.result_bits = sign | q;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'hff;                          // NaN or infinity
            1: v[30:23] = 8'h00;                          // zero or subnormal
            2: v[30:23] = 8'(254 - $urandom_range(0, 3));
            3: v[30:23] = 8'($urandom_range(1, 4));
            4: v[22:0] = 23'($urandom_range(0, 15));      // sparse fraction
            default: ;
        endcase
        if (v[30:23] == 8'h00 && $urandom_range(0, 1)) v[22:0] = v[22:0] >> $urandom_range(0, 22);
        return v;
    endfunction

    function automatic logic [31:0] random_scale();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'(-$urandom_range(0, 300));
            2: return 32'($urandom_range(0, 300));
            3: return 32'(-$urandom_range(100, 180));     // around the subnormal edge
            4: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'(int'($urandom_range(0, 60)) - 30);
        endcase
    endfunction

    task automatic add_request(logic [31:0] x, logic [31:0] scale);
        request_t req;
        req.x_bits = x;
        req.scale = scale;
        pending_requests.push_back(req);
    endtask

    initial begin
        // zeros, infinities, NaNs, zero scale, extremes, subnormal rounding
        add_request(32'h0000_0000, 32'd5);
        add_request(32'h8000_0000, 32'h8000_0000);
        add_request(32'h7f80_0000, 32'h7fff_ffff);
        add_request(32'hff80_0000, 32'hffff_ffff);
        add_request(32'h7fc0_0001, 32'd3);
        add_request(32'h7f80_0001, 32'd3);
        add_request(32'hffbf_ffff, 32'd0);
        add_request(32'h0000_0001, 32'd0);
        add_request(32'h3f80_0000, 32'd0);
        add_request(32'h3f80_0000, 32'd127);
        add_request(32'h3f80_0000, 32'd128);
        add_request(32'hbf80_0000, 32'h7fff_ffff);
        add_request(32'h7f7f_ffff, 32'd1);
        add_request(32'h3f80_0000, 32'(-126));
        add_request(32'h3f80_0000, 32'(-149));
        add_request(32'h3f80_0000, 32'(-150));
        add_request(32'h3fc0_0000, 32'(-150));
        add_request(32'hbf80_0000, 32'(-151));
        add_request(32'h3fff_ffff, 32'(-127));
        add_request(32'h0000_0001, 32'd1);
        add_request(32'h0000_0001, 32'(-1));
        add_request(32'h807f_ffff, 32'd1);
        add_request(32'h0040_0000, 32'h8000_0000);
        add_request(32'h0000_0003, 32'd254);
        add_request(32'hffff_ffff, 32'h8000_0000);
        for (int i = 0; i < 450; i++)
            add_request(random_operand(), random_scale());
        stimulus_done = 1'b1;
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // Driver: no gaps between cycles 300 and 700, otherwise ~16% gaps.
    always @(negedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && (!s_tvalid || s_tready_q)) begin
            if (pending_requests.size() != 0 &&
                (cycle_count inside {[300:700]} || $urandom_range(0, 99) >= 16)) begin
                s_tdata <= pending_requests.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sampled acceptance at the rising edge, used by the driver at the next falling edge.
    always @(posedge aclk) begin
        s_tready_q <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
            expected_results.push_back(scale_float(s_tdata[31:0], s_tdata[63:32]));
    end

    // Receiver ready: one long hold-off early on, then random stalls.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!hold_done && cycle_count == 60) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= (cycle_count inside {[800:1200]}) || $urandom_range(0, 99) >= 16;
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        f32sc_pkg::result_t got;
        f32sc_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[32], m_tdata[33], m_tdata[34], m_tdata[35]};
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, m_tdata);
                fail_count <= fail_count + 1;
            end else begin
                want = expected_results.pop_front();
                if (got !== want || m_tdata[39:36] !== 4'b0) begin
                    $display("%0t: mismatch expected bits=%h inv=%b ovf=%b unf=%b inx=%b",
                             $realtime, want.result_bits, want.flag_invalid,
                             want.flag_overflow, want.flag_underflow, want.flag_inexact);
                    $display("%0t:          actual   bits=%h inv=%b ovf=%b unf=%b inx=%b pad=%h",
                             $realtime, got.result_bits, got.flag_invalid,
                             got.flag_overflow, got.flag_underflow, got.flag_inexact,
                             m_tdata[39:36]);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    // Watchdog on cycles with no request or result moving.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        wait (aresetn && stimulus_done && pending_requests.size() == 0);
        @(posedge aclk);
        wait (!s_tvalid && expected_results.size() == 0);
        repeat (10) @(posedge aclk);
        $display("Covered %0d scale requests: NaN/inf/zero pass-through, overflow,", results_seen);
        $display("subnormal rounding and flush to zero, with stalls on both sides.");
        if (fail_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
